[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL; all run on aclk and are
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define AST_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define AST_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/im2col_ag_pkg.sv]
// ----------------------------------------------------------------------------
// im2col address generator package
// Channel widths, request and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package im2col_ag_pkg;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int SRC_W = 25;
    localparam int DST_W = 35;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_Y         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd7;

    typedef enum logic [2:0] {
        ST_READY,
        ST_MUL,
        ST_OFFSET,
        ST_ADDR,
        ST_SUM,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic mul;
        logic offset;
        logic addr;
        logic sum;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic wrap;
    } dp_status_t;

endpackage

[hw/rtl/im2col_ag_ctrl.sv]
// ----------------------------------------------------------------------------
// im2col address generator controller
// Accepts requests, sequences the datapath steps and owns the result valid.
// ----------------------------------------------------------------------------
module im2col_ag_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  im2col_ag_pkg::dp_status_t status,
    output im2col_ag_pkg::dp_cmd_t    cmd
);
    import im2col_ag_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_READY;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_READY: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == REQ_START) begin
                        cmd.start = 1'b1;
                    end else if (status.busy) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_OFFSET;
            end
            ST_OFFSET: begin
                cmd.offset = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_READY;
                end
            end
            default: begin
                state_next = ST_READY;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[hw/rtl/im2col_ag_dp.sv]
// ----------------------------------------------------------------------------
// im2col address generator datapath
// Config registers, walk counters and the four-step multiply/add chain that
// forms the source address and destination index of one column element.
// ----------------------------------------------------------------------------
module im2col_ag_dp #(
    parameter int MAX_DIM    = 256,
    parameter int MAX_PLANES = 512,
    parameter int MAX_KERNEL = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_write,
    input  logic [im2col_ag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [im2col_ag_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [9:0]                             plane_count,
    input  logic [8:0]                             out_width,
    input  logic [8:0]                             out_height,
    input  im2col_ag_pkg::dp_cmd_t                 cmd,
    output im2col_ag_pkg::dp_status_t              status,
    output logic [im2col_ag_pkg::SRC_W-1:0]        src_address,
    output logic                                   zero_fill,
    output logic [im2col_ag_pkg::DST_W-1:0]        dst_index,
    output logic                                   last,
    output logic                                   idle_error
);
    import im2col_ag_pkg::*;

    localparam int PLANE_CW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int KER_CW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int DIM_CW   = $clog2(MAX_DIM);
    localparam int SC_W     = DIM_CW + 5;
    localparam int IX_W     = DIM_CW + 6;
    localparam int PK_W     = PLANE_CW + 5;
    localparam int PKR_W    = PLANE_CW + 11;
    localparam int KID_W    = PLANE_CW + 12;
    localparam int OROW_W   = DIM_CW + 9;
    localparam int PHW_W    = PLANE_CW + 18;
    localparam int DHI_W    = KID_W + 18;
    localparam int OC_W     = ((DIM_CW > 9) ? DIM_CW : 9) + 1;
    localparam int KC_W     = ((KER_CW > 5) ? KER_CW : 5) + 1;
    localparam int PC_W     = ((PLANE_CW > 10) ? PLANE_CW : 10) + 1;

    // config registers
    logic [4:0] kernel_width_reg, kernel_height_reg, stride_x_reg, stride_y_reg;
    logic [3:0] pad_x_reg, pad_y_reg;
    logic [8:0] image_width_reg, image_height_reg;

    // walk state
    logic [PLANE_CW-1:0] plane_ctr_reg;
    logic [KER_CW-1:0]   krow_ctr_reg, kcol_ctr_reg;
    logic [DIM_CW-1:0]   orow_ctr_reg, ocol_ctr_reg;
    logic [9:0]          planes_held_reg;
    logic [8:0]          out_w_held_reg, out_h_held_reg;
    logic                busy_reg;

    // step registers
    logic [SC_W-1:0]   ysc_reg, xsc_reg;
    logic [PK_W-1:0]   pk_reg;
    logic [17:0]       hw_reg, ohw_reg;
    logic [OROW_W-1:0] orow_ow_reg;
    logic [IX_W-1:0]   iy_reg, ix_reg;
    logic [SRC_W-1:0]  phw_reg;
    logic [PKR_W-1:0]  pkr_reg;
    logic              fill_reg;
    logic [17:0]       row_off_reg;
    logic [KID_W-1:0]  kidx_reg;
    logic [SRC_W-1:0]  src_reg;
    logic [DST_W-1:0]  dhi_reg;

    // result register
    logic [SRC_W-1:0] out_src_reg;
    logic             out_fill_reg;
    logic [DST_W-1:0] out_dst_reg;
    logic             out_last_reg;
    logic             out_err_reg;

    logic [4:0] kw_c, kh_c, sx_c, sy_c;
    logic [8:0] w_c, h_c;
    logic [9:0] planes_c;
    logic [8:0] ow_c, oh_c;

    logic [SC_W-1:0]   ysc_full, xsc_full;
    logic [PK_W-1:0]   pk_full;
    logic [17:0]       hw_full, ohw_full, row_off_full;
    logic [OROW_W-1:0] orow_ow_full;
    logic [PHW_W-1:0]  phw_full;
    logic [PKR_W-1:0]  pkr_full;
    logic [DHI_W-1:0]  dhi_full;
    logic              iy_out, ix_out;

    logic wrap_ocol, wrap_orow, wrap_kcol, wrap_krow, wrap_plane, wrap_all;

    // live clamps of the config registers
    always_comb begin
        kw_c = (kernel_width_reg == 5'd0) ? 5'd1 :
               (32'(kernel_width_reg) > MAX_KERNEL) ? 5'(MAX_KERNEL) : kernel_width_reg;
        kh_c = (kernel_height_reg == 5'd0) ? 5'd1 :
               (32'(kernel_height_reg) > MAX_KERNEL) ? 5'(MAX_KERNEL) : kernel_height_reg;
        sx_c = (stride_x_reg == 5'd0) ? 5'd1 : (stride_x_reg > 5'd16) ? 5'd16 : stride_x_reg;
        sy_c = (stride_y_reg == 5'd0) ? 5'd1 : (stride_y_reg > 5'd16) ? 5'd16 : stride_y_reg;
        w_c  = (image_width_reg == 9'd0) ? 9'd1 :
               (32'(image_width_reg) > MAX_DIM) ? 9'(MAX_DIM) : image_width_reg;
        h_c  = (image_height_reg == 9'd0) ? 9'd1 :
               (32'(image_height_reg) > MAX_DIM) ? 9'(MAX_DIM) : image_height_reg;
    end

    // start operand clamps
    always_comb begin
        planes_c = (plane_count == 10'd0) ? 10'd1 :
                   (32'(plane_count) > MAX_PLANES) ? 10'(MAX_PLANES) : plane_count;
        ow_c     = (out_width == 9'd0) ? 9'd1 :
                   (32'(out_width) > MAX_DIM) ? 9'(MAX_DIM) : out_width;
        oh_c     = (out_height == 9'd0) ? 9'd1 :
                   (32'(out_height) > MAX_DIM) ? 9'(MAX_DIM) : out_height;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_width_reg  <= 5'd3;
            kernel_height_reg <= 5'd3;
            stride_x_reg      <= 5'd1;
            stride_y_reg      <= 5'd1;
            pad_x_reg         <= 4'd0;
            pad_y_reg         <= 4'd0;
            image_width_reg   <= 9'd32;
            image_height_reg  <= 9'd32;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[4:0];
                CFG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[4:0];
                CFG_STRIDE_X:      stride_x_reg      <= cfg_data[4:0];
                CFG_STRIDE_Y:      stride_y_reg      <= cfg_data[4:0];
                CFG_PAD_X:         pad_x_reg         <= cfg_data[3:0];
                CFG_PAD_Y:         pad_y_reg         <= cfg_data[3:0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // step 1: independent products
    assign ysc_full     = SC_W'(orow_ctr_reg) * SC_W'(sy_c);
    assign xsc_full     = SC_W'(ocol_ctr_reg) * SC_W'(sx_c);
    assign pk_full      = PK_W'(plane_ctr_reg) * PK_W'(kh_c);
    assign hw_full      = 18'(h_c) * 18'(w_c);
    assign ohw_full     = 18'(out_h_held_reg) * 18'(out_w_held_reg);
    assign orow_ow_full = OROW_W'(orow_ctr_reg) * OROW_W'(out_w_held_reg);

    // step 2 and 3 products
    assign phw_full     = PHW_W'(plane_ctr_reg) * PHW_W'(hw_reg);
    assign pkr_full     = (PKR_W'(pk_reg) + PKR_W'(krow_ctr_reg)) * PKR_W'(kw_c);
    assign row_off_full = 18'(iy_reg[8:0]) * 18'(w_c);
    assign iy_out       = iy_reg[IX_W-1] || (iy_reg >= IX_W'(h_c));
    assign ix_out       = ix_reg[IX_W-1] || (ix_reg >= IX_W'(w_c));

    // step 4 product
    assign dhi_full     = DHI_W'(kidx_reg) * DHI_W'(ohw_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            ysc_reg     <= ysc_full;
            xsc_reg     <= xsc_full;
            pk_reg      <= pk_full;
            hw_reg      <= hw_full;
            ohw_reg     <= ohw_full;
            orow_ow_reg <= orow_ow_full;
        end
        if (cmd.offset) begin
            iy_reg  <= IX_W'(ysc_reg) + IX_W'(krow_ctr_reg) - IX_W'(pad_y_reg);
            ix_reg  <= IX_W'(xsc_reg) + IX_W'(kcol_ctr_reg) - IX_W'(pad_x_reg);
            phw_reg <= SRC_W'(phw_full);
            pkr_reg <= pkr_full;
        end
        if (cmd.addr) begin
            fill_reg    <= iy_out || ix_out;
            row_off_reg <= row_off_full;
            kidx_reg    <= KID_W'(pkr_reg) + KID_W'(kcol_ctr_reg);
        end
        if (cmd.sum) begin
            src_reg <= fill_reg ? '0 :
                       SRC_W'(phw_reg + SRC_W'(row_off_reg) + SRC_W'(ix_reg[8:0]));
            dhi_reg <= DST_W'(dhi_full);
        end
        if (cmd.emit) begin
            if (busy_reg) begin
                out_src_reg  <= src_reg;
                out_fill_reg <= fill_reg;
                out_dst_reg  <= DST_W'(dhi_reg + DST_W'(orow_ow_reg) + DST_W'(ocol_ctr_reg));
                out_last_reg <= wrap_all;
                out_err_reg  <= 1'b0;
            end else begin
                out_src_reg  <= '0;
                out_fill_reg <= 1'b0;
                out_dst_reg  <= '0;
                out_last_reg <= 1'b0;
                out_err_reg  <= 1'b1;
            end
        end
    end

    // counter wraps; a counter at or past its bound wraps too
    assign wrap_ocol  = (OC_W'(ocol_ctr_reg) + OC_W'(1)) >= OC_W'(out_w_held_reg);
    assign wrap_orow  = (OC_W'(orow_ctr_reg) + OC_W'(1)) >= OC_W'(out_h_held_reg);
    assign wrap_kcol  = (KC_W'(kcol_ctr_reg) + KC_W'(1)) >= KC_W'(kw_c);
    assign wrap_krow  = (KC_W'(krow_ctr_reg) + KC_W'(1)) >= KC_W'(kh_c);
    assign wrap_plane = (PC_W'(plane_ctr_reg) + PC_W'(1)) >= PC_W'(planes_held_reg);
    assign wrap_all   = wrap_ocol && wrap_orow && wrap_kcol && wrap_krow && wrap_plane;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_ctr_reg   <= '0;
            krow_ctr_reg    <= '0;
            kcol_ctr_reg    <= '0;
            orow_ctr_reg    <= '0;
            ocol_ctr_reg    <= '0;
            planes_held_reg <= '0;
            out_w_held_reg  <= '0;
            out_h_held_reg  <= '0;
            busy_reg        <= 1'b0;
        end else if (cmd.start) begin
            plane_ctr_reg   <= '0;
            krow_ctr_reg    <= '0;
            kcol_ctr_reg    <= '0;
            orow_ctr_reg    <= '0;
            ocol_ctr_reg    <= '0;
            planes_held_reg <= planes_c;
            out_w_held_reg  <= ow_c;
            out_h_held_reg  <= oh_c;
            busy_reg        <= 1'b1;
        end else if (cmd.emit && busy_reg) begin
            ocol_ctr_reg <= wrap_ocol ? '0 : ocol_ctr_reg + 1'b1;
            if (wrap_ocol) begin
                orow_ctr_reg <= wrap_orow ? '0 : orow_ctr_reg + 1'b1;
                if (wrap_orow) begin
                    kcol_ctr_reg <= wrap_kcol ? '0 : kcol_ctr_reg + 1'b1;
                    if (wrap_kcol) begin
                        krow_ctr_reg <= wrap_krow ? '0 : krow_ctr_reg + 1'b1;
                        if (wrap_krow) begin
                            plane_ctr_reg <= wrap_plane ? '0 : plane_ctr_reg + 1'b1;
                        end
                    end
                end
            end
            if (wrap_all) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.wrap = wrap_all;

    assign src_address = out_src_reg;
    assign zero_fill   = out_fill_reg;
    assign dst_index   = out_dst_reg;
    assign last        = out_last_reg;
    assign idle_error  = out_err_reg;

endmodule

[hw/rtl/im2col_address_generator_unit.sv]
// ----------------------------------------------------------------------------
// im2col address generator
// Walks the column matrix of one image with padding and stride, one element
// per next request, giving source address, zero fill and destination index.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  s_*      in         start (plane count, output extents) or next request
//  m_*      out        one column element or an idle error
//  cfg_*    in         register index and write data
//
// Next request: accept, then the four datapath steps of the multiply/add
// chain, then emit; no new request is taken before emit. Next while idle:
// accept, then emit. Start: no result. The result register lets the next
// request be taken while a result waits; emit stalls until m_tready frees it.
// Reset (aresetn low, synchronous) clears the walk and restores register
// defaults.
`include "assert_macros.svh"

module im2col_address_generator_unit #(
    parameter int MAX_DIM    = 256,
    parameter int MAX_PLANES = 512,
    parameter int MAX_KERNEL = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // plane_count[9:0], out_width[18:10], out_height[27:19]
    input  logic [im2col_ag_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // src_address[24:0], zero_fill[25], dst_index[60:26]
    output logic [im2col_ag_pkg::M_TDATA_W-1:0]    m_tdata,
    // idle_error
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [im2col_ag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [im2col_ag_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import im2col_ag_pkg::*;

    dp_cmd_t          ctrl_cmd;
    dp_status_t       dp_status;
    logic [SRC_W-1:0] src_address;
    logic             zero_fill;
    logic [DST_W-1:0] dst_index;

    assign cfg_ready = 1'b1;

    im2col_ag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    im2col_ag_dp #(
        .MAX_DIM    (MAX_DIM),
        .MAX_PLANES (MAX_PLANES),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .plane_count (s_tdata[9:0]),
        .out_width   (s_tdata[18:10]),
        .out_height  (s_tdata[27:19]),
        .cmd         (ctrl_cmd),
        .status      (dp_status),
        .src_address (src_address),
        .zero_fill   (zero_fill),
        .dst_index   (dst_index),
        .last        (m_tlast),
        .idle_error  (m_tuser)
    );

    assign m_tdata = {3'b000, dst_index, zero_fill, src_address};

    `AST_IMPLIES(a_err_payload_zero, m_tvalid && m_tuser, (m_tdata == '0) && !m_tlast, "idle error result carries data")
    `AST_NEXT(a_last_ends_walk, ctrl_cmd.emit && dp_status.busy && dp_status.wrap, !dp_status.busy, "walk still active after last element")
    `AST_NEXT(a_idle_next_errors, ctrl_cmd.emit && !dp_status.busy, m_tvalid && m_tuser, "next while idle gave no error result")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// im2col address generator testbench
// Drives start and next items into the address generator and checks every
// result against a cycle-free model of the column walk: source address,
// zero fill, destination index, last flag and idle error. A short table of
// directed items comes first, then randomized walks under varied register
// settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import im2col_ag_pkg::*;

    localparam int MAX_DIM     = 256;
    localparam int MAX_PLANES  = 512;
    localparam int MAX_KERNEL  = 16;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 208;

    typedef struct packed {
        bit [SRC_W-1:0] src;
        bit             zero_fill;
        bit [DST_W-1:0] dst;
        bit             last;
        bit             idle_err;
    } col_elem_t;

    typedef enum bit [0:0] {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        bit                    req;
        bit [9:0]              planes;
        bit [8:0]              ow;
        bit [8:0]              oh;
        bit [CFG_IDX_W-1:0]    idx;
        bit [CFG_DATA_W-1:0]   val;
        bit                    typed;
        col_elem_t             elem;
    } dir_row_t;

    localparam col_elem_t IDLE_ERR_ELEM = '{'0, 1'b0, '0, 1'b0, 1'b1};
    localparam col_elem_t FIRST_ELEM    = '{'0, 1'b0, '0, 1'b0, 1'b0};

    localparam dir_row_t DIRECTED[30] = '{
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b1, IDLE_ERR_ELEM},
        '{ROW_ITEM, REQ_START, 10'd0,    9'd0,   9'd0,   '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b1, FIRST_ELEM},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd1023, 9'd511, 9'd511, '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b1,
          '{25'd66, 1'b0, 35'd8, 1'b1, 1'b0}},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b1, IDLE_ERR_ELEM},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_KERNEL_WIDTH,  9'd0,     1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_KERNEL_HEIGHT, 9'd0,     1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_STRIDE_X,      9'h1FF,   1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_STRIDE_Y,      9'd16,    1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_PAD_X,         9'h1FF,   1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_PAD_Y,         9'd15,    1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_IMAGE_WIDTH,   9'h1FF,   1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_IMAGE_HEIGHT,  9'd0,     1'b0, '0},
        '{ROW_ITEM, REQ_START, 10'd1023, 9'd511, 9'd511, '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b1,
          '{25'd0, 1'b1, 35'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b0, '0},
        '{ROW_ITEM, REQ_START, 10'd1,    9'd2,   9'd1,   '0, '0, 1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_PAD_X,         9'd0,     1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_PAD_Y,         9'd0,     1'b0, '0},
        '{ROW_CFG,  REQ_NEXT,  '0, '0, '0, CFG_IMAGE_WIDTH,   9'd1,     1'b0, '0},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b1, FIRST_ELEM},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b1,
          '{25'd0, 1'b1, 35'd1, 1'b1, 1'b0}},
        '{ROW_ITEM, REQ_NEXT,  10'd0,    9'd0,   9'd0,   '0, '0, 1'b1, IDLE_ERR_ELEM}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    im2col_address_generator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // walk model state
    int  reg_file[8];
    int  plane_ctr, krow_ctr, kcol_ctr, orow_ctr, ocol_ctr;
    int  planes_held, out_w_held, out_h_held;
    bit  walk_busy;

    col_elem_t pending_elems[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_kicks     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    int fail_count     = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int fills_seen     = 0;
    int idle_errs_seen = 0;
    int walks_done     = 0;
    int cfg_writes     = 0;

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_reg(bit [CFG_IDX_W-1:0] idx);
        case (idx)
            CFG_KERNEL_WIDTH, CFG_KERNEL_HEIGHT: return clamp(reg_file[idx], 1, MAX_KERNEL);
            CFG_STRIDE_X, CFG_STRIDE_Y:          return clamp(reg_file[idx], 1, 16);
            CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT:   return clamp(reg_file[idx], 1, MAX_DIM);
            default:                             return reg_file[idx];
        endcase
    endfunction

    function automatic void store_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PAD_X, CFG_PAD_Y:              reg_file[idx] = int'(val & 9'h00F);
            CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: reg_file[idx] = int'(val);
            default:                           reg_file[idx] = int'(val & 9'h01F);
        endcase
    endfunction

    function automatic bit bump(inout int ctr, input int bound);
        if (ctr + 1 >= bound) begin
            ctr = 0;
            return 1'b1;
        end
        ctr = ctr + 1;
        return 1'b0;
    endfunction

    function automatic void walk_step(input bit req, input bit [9:0] pc, input bit [8:0] ow,
                                      input bit [8:0] oh, output bit has_result,
                                      output col_elem_t elem);
        longint kw, kh, sx, sy, w, h, iy, ix;
        bit [63:0] addr;
        bit fill, wrap;
        elem = '0;
        has_result = 1'b0;
        if (req == REQ_START) begin
            planes_held = clamp(int'(pc), 1, MAX_PLANES);
            out_w_held  = clamp(int'(ow), 1, MAX_DIM);
            out_h_held  = clamp(int'(oh), 1, MAX_DIM);
            plane_ctr = 0; krow_ctr = 0; kcol_ctr = 0; orow_ctr = 0; ocol_ctr = 0;
            walk_busy = 1'b1;
            return;
        end
        has_result = 1'b1;
        if (!walk_busy) begin
            elem.idle_err = 1'b1;
            return;
        end
        kw = eff_reg(CFG_KERNEL_WIDTH);
        kh = eff_reg(CFG_KERNEL_HEIGHT);
        sx = eff_reg(CFG_STRIDE_X);
        sy = eff_reg(CFG_STRIDE_Y);
        w  = eff_reg(CFG_IMAGE_WIDTH);
        h  = eff_reg(CFG_IMAGE_HEIGHT);
        iy = orow_ctr * sy - reg_file[CFG_PAD_Y] + krow_ctr;
        ix = ocol_ctr * sx - reg_file[CFG_PAD_X] + kcol_ctr;
        fill = iy < 0 || iy >= h || ix < 0 || ix >= w;
        if (!fill) begin
            addr = plane_ctr * h * w + iy * w + ix;
            elem.src = addr[SRC_W-1:0];
        end
        elem.zero_fill = fill;
        addr = ((longint'(plane_ctr) * kh + krow_ctr) * kw + kcol_ctr)
               * out_h_held * out_w_held + longint'(orow_ctr) * out_w_held + ocol_ctr;
        elem.dst = addr[DST_W-1:0];
        wrap = bump(ocol_ctr, out_w_held);
        if (wrap) wrap = bump(orow_ctr, out_h_held);
        if (wrap) wrap = bump(kcol_ctr, int'(kw));
        if (wrap) wrap = bump(krow_ctr, int'(kh));
        if (wrap) wrap = bump(plane_ctr, planes_held);
        elem.last = wrap;
        if (wrap) walk_busy = 1'b0;
    endfunction

    task automatic send_item(input bit req, input bit [9:0] pc, input bit [8:0] ow,
                             input bit [8:0] oh, input bit typed, input col_elem_t typed_elem);
        bit has_result;
        col_elem_t elem;
        @(negedge aclk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, oh, ow, pc};
        do @(posedge aclk); while (!s_tready);
        items_accepted++;
        walk_step(req, pc, ow, oh, has_result, elem);
        if (has_result) pending_elems.push_back(typed ? typed_elem : elem);
    endtask

    task automatic next_item();
        send_item(REQ_NEXT, 10'($urandom), 9'($urandom), 9'($urandom), 1'b0, '0);
    endtask

    // sender pauses until every expected result is back and the block is quiet
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        store_reg(idx, val);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // leaves a walk half done, rewrites every register, then resumes it
    task automatic reconfigure();
        int r;
        bit [CFG_DATA_W-1:0] val;
        send_item(REQ_START, 10'd2, 9'd3, 9'd2, 1'b0, '0);
        repeat ($urandom_range(1, 8)) next_item();
        drain();
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 7);
            if (r == 0) val = '0;
            else if (r == 1) val = '1;
            else if (r == 2) val = CFG_DATA_W'($urandom);
            else case (i)
                CFG_KERNEL_WIDTH, CFG_KERNEL_HEIGHT: val = CFG_DATA_W'($urandom_range(1, 4));
                CFG_STRIDE_X, CFG_STRIDE_Y:          val = CFG_DATA_W'($urandom_range(1, 3));
                CFG_PAD_X, CFG_PAD_Y:                val = CFG_DATA_W'($urandom_range(0, 2));
                default:                             val = CFG_DATA_W'($urandom_range(2, 10));
            endcase
            write_reg(CFG_IDX_W'(i), val);
        end
        repeat (4) next_item();
    endtask

    task automatic run_walks(input int quota);
        int target, n, len, r;
        bit [9:0] pc;
        bit [8:0] ow, oh;
        target = items_accepted + quota;
        while (items_accepted < target) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                next_item();
            end else if (r < 12) begin
                send_item(REQ_START, 10'($urandom), 9'($urandom), 9'($urandom), 1'b0, '0);
                repeat ($urandom_range(0, 6)) next_item();
            end else begin
                pc = 10'($urandom_range(1, 3));
                ow = 9'($urandom_range(1, 5));
                oh = 9'($urandom_range(1, 4));
                len = int'(pc) * int'(ow) * int'(oh)
                      * eff_reg(CFG_KERNEL_WIDTH) * eff_reg(CFG_KERNEL_HEIGHT);
                if (len > 80) n = $urandom_range(1, 40);
                else n = len + int'($urandom_range(0, 3) == 0);
                send_item(REQ_START, pc, ow, oh, 1'b0, '0);
                repeat (n) next_item();
            end
        end
    endtask

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_kicks != hold_seen) begin
            hold_seen = hold_kicks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        col_elem_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata[SRC_W]) fills_seen++;
            if (m_tuser) idle_errs_seen++;
            if (m_tlast) walks_done++;
            if (pending_elems.size() == 0) begin
                $error("unexpected item: m_tdata=%h m_tuser=%b m_tlast=%b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want = pending_elems.pop_front();
                check_field("src_address", 64'(want.src), 64'(m_tdata[SRC_W-1:0]));
                check_field("zero_fill", 64'(want.zero_fill), 64'(m_tdata[SRC_W]));
                check_field("dst_index", 64'(want.dst), 64'(m_tdata[SRC_W+DST_W:SRC_W+1]));
                check_field("last", 64'(want.last), 64'(m_tlast));
                check_field("idle_error", 64'(want.idle_err), 64'(m_tuser));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 73, 0, 21};
        recv_pct = '{0, 0, 73, 21};
        reg_file = '{3, 3, 1, 1, 0, 0, 32, 32};
        walk_busy = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                drain();
                write_reg(DIRECTED[i].idx, DIRECTED[i].val);
            end else begin
                send_item(DIRECTED[i].req, DIRECTED[i].planes, DIRECTED[i].ow,
                          DIRECTED[i].oh, DIRECTED[i].typed, DIRECTED[i].elem);
            end
        end

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            for (int s = 0; s < 2; s++) begin
                reconfigure();
                if (p == 0 && s == 0) begin
                    // receiver holds off while the sender keeps pushing
                    hold_kicks++;
                    send_item(REQ_START, 10'd3, 9'd4, 9'd4, 1'b0, '0);
                    repeat (48) next_item();
                end
                run_walks(PHASE_ITEMS);
            end
        end

        drain();
        $display("Covered %0d items in, %0d results out, %0d register writes.",
                 items_accepted, results_seen, cfg_writes);
        $display("Walks ended: %0d, zero fills: %0d, idle errors: %0d.",
                 walks_done, fills_seen, idle_errs_seen);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
